// ===== rtl/wls_pkg.sv =====
// Shared types, codes and constants of the wireless link supervisor.
`timescale 1ns / 1ps
package wls_pkg;

    localparam int ADDR_W     = 48;
    localparam int TIME_W     = 32;
    localparam int TMO_W      = 16;
    localparam int CNT_W      = 4;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CNT_W-1:0] BAD_LIMIT = 4'd10;
    localparam logic [CNT_W-1:0] BAD_SAT   = 4'd15;

    localparam logic [TMO_W-1:0] ACTIVE_TIMEOUT_RST   = 16'd200;
    localparam logic [TMO_W-1:0] INACTIVE_TIMEOUT_RST = 16'd10000;
    localparam logic [TMO_W-1:0] BAD_WINDOW_RST       = 16'd50;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_LOST      = 3'd1,
        EV_INACTIVE  = 3'd2,
        EV_BAD_DATA  = 3'd3,
        EV_REJECTED  = 3'd4,
        EV_ACCEPTED  = 3'd5,
        EV_LEARNED   = 3'd6
    } event_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACTIVE_TIMEOUT   = 3'd0,
        REG_INACTIVE_TIMEOUT = 3'd1,
        REG_BAD_WINDOW       = 3'd2,
        REG_CRITICAL         = 3'd3,
        REG_PRIMARY_ADDR     = 3'd4,
        REG_PRIMARY_VALID    = 3'd5,
        REG_BACKUP_ADDR      = 3'd6,
        REG_BACKUP_VALID     = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [TMO_W-1:0]  active_timeout;
        logic [TMO_W-1:0]  inactive_timeout;
        logic [TMO_W-1:0]  bad_window;
        logic              critical;
        logic [ADDR_W-1:0] primary_addr;
        logic              primary_valid;
        logic [ADDR_W-1:0] backup_addr;
        logic              backup_valid;
    } cfg_t;

    typedef struct packed {
        logic              func;
        logic [TIME_W-1:0] now_ms;
        logic [TIME_W-1:0] reported_time;
        logic              link_up;
        logic              status_known;
        logic [ADDR_W-1:0] device_addr;
    } item_t;

    typedef struct packed {
        logic       connected;
        logic       waiting_reconnect;
        logic       active_warn;
        logic       drop_link;
        logic [2:0] event_code;
    } result_t;

endpackage

// ===== rtl/wls_item_if.sv =====
// Input item channel: valid/ready handshake with the supervisor's input fields.
`timescale 1ns / 1ps
interface wls_item_if;
    logic                       valid;
    logic                       ready;
    logic                       func;
    logic [wls_pkg::TIME_W-1:0] now_ms;
    logic [wls_pkg::TIME_W-1:0] reported_time;
    logic                       link_up;
    logic                       status_known;
    logic [wls_pkg::ADDR_W-1:0] device_addr;

    modport source (
        output valid, func, now_ms, reported_time, link_up, status_known, device_addr,
        input  ready
    );
    modport sink (
        input  valid, func, now_ms, reported_time, link_up, status_known, device_addr,
        output ready
    );
endinterface

// ===== rtl/wls_result_if.sv =====
// Result item channel: valid/ready handshake with the supervisor's output fields.
`timescale 1ns / 1ps
interface wls_result_if;
    logic       valid;
    logic       ready;
    logic       connected;
    logic       waiting_reconnect;
    logic       active_warn;
    logic       drop_link;
    logic [2:0] event_code;

    modport source (
        output valid, connected, waiting_reconnect, active_warn, drop_link, event_code,
        input  ready
    );
    modport sink (
        input  valid, connected, waiting_reconnect, active_warn, drop_link, event_code,
        output ready
    );
endinterface

// ===== rtl/wls_cfg.sv =====
// Configuration register file of the supervisor.
`timescale 1ns / 1ps
module wls_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [wls_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wls_pkg::CFG_DATA_W-1:0] cfg_data,
    output wls_pkg::cfg_t                  cfg
);

    wls_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_timeout   <= wls_pkg::ACTIVE_TIMEOUT_RST;
            cfg_reg.inactive_timeout <= wls_pkg::INACTIVE_TIMEOUT_RST;
            cfg_reg.bad_window       <= wls_pkg::BAD_WINDOW_RST;
            cfg_reg.critical         <= 1'b0;
            cfg_reg.primary_addr     <= '0;
            cfg_reg.primary_valid    <= 1'b0;
            cfg_reg.backup_addr      <= '0;
            cfg_reg.backup_valid     <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (wls_pkg::cfg_idx_t'(cfg_index))
                wls_pkg::REG_ACTIVE_TIMEOUT:
                    cfg_reg.active_timeout <= cfg_data[wls_pkg::TMO_W-1:0];
                wls_pkg::REG_INACTIVE_TIMEOUT:
                    cfg_reg.inactive_timeout <= cfg_data[wls_pkg::TMO_W-1:0];
                wls_pkg::REG_BAD_WINDOW:
                    cfg_reg.bad_window <= cfg_data[wls_pkg::TMO_W-1:0];
                wls_pkg::REG_CRITICAL:
                    cfg_reg.critical <= cfg_data[0];
                wls_pkg::REG_PRIMARY_ADDR:
                    cfg_reg.primary_addr <= cfg_data[wls_pkg::ADDR_W-1:0];
                wls_pkg::REG_PRIMARY_VALID:
                    cfg_reg.primary_valid <= cfg_data[0];
                wls_pkg::REG_BACKUP_ADDR:
                    cfg_reg.backup_addr <= cfg_data[wls_pkg::ADDR_W-1:0];
                wls_pkg::REG_BACKUP_VALID:
                    cfg_reg.backup_valid <= cfg_data[0];
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/wls_core.sv =====
// Link state registers and the per-item update logic of the supervisor.
`timescale 1ns / 1ps
module wls_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  wls_pkg::item_t    it,
    input  wls_pkg::cfg_t     cfg,
    output wls_pkg::result_t  res
);

    logic                       conn_reg, conn_next;
    logic                       wait_reg, wait_next;
    logic [wls_pkg::TIME_W-1:0] lmt_reg, lmt_next;
    logic [wls_pkg::TIME_W-1:0] lbt_reg, lbt_next;
    logic [wls_pkg::CNT_W-1:0]  bc_reg, bc_next;
    logic [wls_pkg::ADDR_W-1:0] learned_addr_reg, learned_addr_next;
    logic                       learned_valid_reg, learned_valid_next;

    logic [wls_pkg::TIME_W-1:0] lmt_sel;
    logic [wls_pkg::TIME_W-1:0] diff;
    logic                       now_gt;
    logic [wls_pkg::TIME_W-1:0] lag;
    logic                       lag_short;
    logic [wls_pkg::TIME_W:0]   bad_sum;
    logic                       bad_due;
    logic [wls_pkg::CNT_W-1:0]  bc_inc;
    logic                       addr_match;
    logic                       warn;
    logic                       drop;
    wls_pkg::event_t            ev;

    assign lmt_sel   = (it.reported_time > lmt_reg) ? it.reported_time : lmt_reg;
    assign diff      = it.now_ms - lmt_sel;
    assign now_gt    = it.now_ms > lmt_sel;
    assign lag       = (wait_reg || !now_gt) ? '0 : diff[wls_pkg::TIME_W-1:0];
    assign lag_short = diff[wls_pkg::TIME_W-1:0]
                       < {{(wls_pkg::TIME_W-wls_pkg::TMO_W){1'b0}}, cfg.active_timeout};
    assign bad_sum   = {1'b0, lbt_reg}
                       + {{(wls_pkg::TIME_W+1-wls_pkg::TMO_W){1'b0}}, cfg.bad_window};
    assign bad_due   = {1'b0, it.now_ms} > bad_sum;
    assign bc_inc    = (bc_reg == wls_pkg::BAD_SAT) ? bc_reg : bc_reg + 1'b1;
    assign addr_match = (cfg.primary_valid && it.device_addr == cfg.primary_addr)
                     || (cfg.backup_valid && it.device_addr == cfg.backup_addr)
                     || (learned_valid_reg && it.device_addr == learned_addr_reg);

    always_comb
    begin
        conn_next          = conn_reg;
        wait_next          = wait_reg;
        lmt_next           = lmt_reg;
        lbt_next           = lbt_reg;
        bc_next            = bc_reg;
        learned_addr_next  = learned_addr_reg;
        learned_valid_next = learned_valid_reg;
        warn               = 1'b0;
        drop               = 1'b0;
        ev                 = wls_pkg::EV_NONE;

        if (it.func)
        begin
            lmt_next  = it.now_ms;
            conn_next = 1'b1;
            priority if (addr_match)
            begin
                ev = wls_pkg::EV_ACCEPTED;
            end
            else if (!cfg.primary_valid && !learned_valid_reg)
            begin
                learned_addr_next  = it.device_addr;
                learned_valid_next = 1'b1;
                ev                 = wls_pkg::EV_LEARNED;
            end
            else
            begin
                bc_next   = '0;
                lbt_next  = '0;
                lmt_next  = '0;
                wait_next = 1'b0;
                conn_next = 1'b0;
                drop      = 1'b1;
                ev        = wls_pkg::EV_REJECTED;
            end
        end
        else if (conn_reg)
        begin
            if (!it.link_up)
            begin
                wait_next = 1'b1;
                conn_next = 1'b0;
                ev        = wls_pkg::EV_LOST;
            end
            else
            begin
                lmt_next = wait_reg ? it.now_ms : lmt_sel;
                if (wait_reg && lag_short)
                begin
                    wait_next = 1'b0;
                end
                warn = cfg.critical
                       && (lag > {{(wls_pkg::TIME_W-wls_pkg::TMO_W){1'b0}}, cfg.active_timeout});
                priority if (lag > {{(wls_pkg::TIME_W-wls_pkg::TMO_W){1'b0}},
                                    cfg.inactive_timeout})
                begin
                    bc_next   = '0;
                    lbt_next  = '0;
                    lmt_next  = '0;
                    conn_next = 1'b0;
                    wait_next = 1'b1;
                    drop      = 1'b1;
                    ev        = wls_pkg::EV_INACTIVE;
                end
                else if (!it.status_known)
                begin
                    if (bad_due)
                    begin
                        bc_next  = bc_inc;
                        lbt_next = it.now_ms;
                    end
                    if (bc_next > wls_pkg::BAD_LIMIT)
                    begin
                        bc_next   = '0;
                        lbt_next  = '0;
                        lmt_next  = '0;
                        conn_next = 1'b0;
                        wait_next = 1'b1;
                        drop      = 1'b1;
                        ev        = wls_pkg::EV_BAD_DATA;
                    end
                end
                else
                begin
                    bc_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conn_reg          <= 1'b0;
            wait_reg          <= 1'b0;
            lmt_reg           <= '0;
            lbt_reg           <= '0;
            bc_reg            <= '0;
            learned_addr_reg  <= '0;
            learned_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            conn_reg          <= conn_next;
            wait_reg          <= wait_next;
            lmt_reg           <= lmt_next;
            lbt_reg           <= lbt_next;
            bc_reg            <= bc_next;
            learned_addr_reg  <= learned_addr_next;
            learned_valid_reg <= learned_valid_next;
        end
    end

    assign res.connected         = conn_next;
    assign res.waiting_reconnect = wait_next;
    assign res.active_warn       = warn;
    assign res.drop_link         = drop;
    assign res.event_code        = ev;

endmodule

// ===== rtl/wireless_link_supervisor_top.sv =====
// Top level of the wireless link supervisor: input stage, update logic, result stage.
//
// Channels: item (sink) carries ticks (func=0) and connect events (func=1);
// result (source) returns exactly one item per accepted input item, in order.
// Configuration: cfg_wr_en/cfg_index/cfg_data write one register per cycle,
// index 0..7 in the order active_timeout, inactive_timeout, bad_window,
// critical, primary_addr, primary_valid, backup_addr, backup_valid.
// Write configuration only while no item is in flight.
// Result path: an accepted item waits in the input register, then loads the
// result register once that register is empty or its result is being taken.
// Throughput: one item per cycle while the result channel is not stalled;
// the link state registers update in the same cycle the item leaves the
// input register, so the next item sees them.
// Reset (rst_n low, asynchronous): configuration returns to its defaults, the
// link state and learned address clear, both stages empty.
// Stall: while result.ready is low the result register holds; the input
// register still takes one more item, then item.ready drops until the
// result is taken.
`timescale 1ns / 1ps
module wireless_link_supervisor_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [wls_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wls_pkg::CFG_DATA_W-1:0] cfg_data,
    wls_item_if.sink                       item,
    wls_result_if.source                   result
);

    wls_pkg::cfg_t    cfg;
    wls_pkg::item_t   item_reg;
    logic             item_vld_reg;
    wls_pkg::result_t core_res;
    wls_pkg::result_t res_reg;
    logic             res_vld_reg;
    logic             advance;
    logic             take;

    assign advance    = item_vld_reg && (!res_vld_reg || result.ready);
    assign item.ready = !item_vld_reg || advance;
    assign take       = item.valid && item.ready;

    wls_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wls_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .it    (item_reg),
        .cfg   (cfg),
        .res   (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
        end
        else
        begin
            item_vld_reg <= take || (item_vld_reg && !advance);
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.func          <= item.func;
            item_reg.now_ms        <= item.now_ms;
            item_reg.reported_time <= item.reported_time;
            item_reg.link_up       <= item.link_up;
            item_reg.status_known  <= item.status_known;
            item_reg.device_addr   <= item.device_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_vld_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= core_res;
        end
    end

    assign result.valid             = res_vld_reg;
    assign result.connected         = res_reg.connected;
    assign result.waiting_reconnect = res_reg.waiting_reconnect;
    assign result.active_warn       = res_reg.active_warn;
    assign result.drop_link         = res_reg.drop_link;
    assign result.event_code        = res_reg.event_code;

endmodule

// ===== rtl/wls_checker.sv =====
// Port-level checks of the supervisor's result channel, bound to the top level.
`timescale 1ns / 1ps
module wls_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic       connected,
    input logic       waiting_reconnect,
    input logic       active_warn,
    input logic       drop_link,
    input logic [2:0] event_code
);

    a_idle_in_reset: assert property (@(posedge clk) !rst_n |-> !res_valid)
        else $error("result valid during reset");

    a_drop_code: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && drop_link) |->
            (event_code == wls_pkg::EV_INACTIVE || event_code == wls_pkg::EV_BAD_DATA
             || event_code == wls_pkg::EV_REJECTED) && !connected)
        else $error("drop without a drop event");

    a_warn_state: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && active_warn) |-> (connected || event_code == wls_pkg::EV_INACTIVE
                                        || event_code == wls_pkg::EV_BAD_DATA))
        else $error("warning on a link that is not up");

    a_admit_connects: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (event_code == wls_pkg::EV_ACCEPTED
                       || event_code == wls_pkg::EV_LEARNED)) |-> (connected && !drop_link))
        else $error("admitted device but link not connected");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(event_code)
                                       && $stable(connected) && $stable(waiting_reconnect)))
        else $error("stalled result changed");

endmodule

bind wireless_link_supervisor_top wls_checker u_wls_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .res_valid         (result.valid),
    .res_ready         (result.ready),
    .connected         (result.connected),
    .waiting_reconnect (result.waiting_reconnect),
    .active_warn       (result.active_warn),
    .drop_link         (result.drop_link),
    .event_code        (result.event_code)
);

// ===== verif/testbench.sv =====
// Self-checking testbench of the wireless link supervisor: directed and random item streams.
`timescale 1ns / 1ps
module testbench;

    class link_scoreboard;
        wls_pkg::cfg_t              cfg;
        logic                       is_conn;
        logic                       wait_rc;
        logic                       learned_ok;
        logic [wls_pkg::TIME_W-1:0] last_msg;
        logic [wls_pkg::TIME_W-1:0] last_bad;
        logic [wls_pkg::CNT_W-1:0]  bad_cnt;
        logic [wls_pkg::ADDR_W-1:0] learned;
        wls_pkg::result_t           expected_status[$];
        int                         errors;
        int                         items;
        int                         ev_count[7];

        function new();
            cfg = '0;
            cfg.active_timeout   = wls_pkg::ACTIVE_TIMEOUT_RST;
            cfg.inactive_timeout = wls_pkg::INACTIVE_TIMEOUT_RST;
            cfg.bad_window       = wls_pkg::BAD_WINDOW_RST;
            is_conn    = 1'b0;
            wait_rc    = 1'b0;
            learned_ok = 1'b0;
            last_msg   = '0;
            last_bad   = '0;
            bad_cnt    = '0;
            learned    = '0;
            errors     = 0;
            items      = 0;
            foreach (ev_count[i]) ev_count[i] = 0;
        endfunction

        function void write_reg(wls_pkg::cfg_idx_t idx,
                                logic [wls_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                wls_pkg::REG_ACTIVE_TIMEOUT:
                    cfg.active_timeout   = data[wls_pkg::TMO_W-1:0];
                wls_pkg::REG_INACTIVE_TIMEOUT:
                    cfg.inactive_timeout = data[wls_pkg::TMO_W-1:0];
                wls_pkg::REG_BAD_WINDOW:
                    cfg.bad_window       = data[wls_pkg::TMO_W-1:0];
                wls_pkg::REG_CRITICAL:
                    cfg.critical         = data[0];
                wls_pkg::REG_PRIMARY_ADDR:
                    cfg.primary_addr     = data[wls_pkg::ADDR_W-1:0];
                wls_pkg::REG_PRIMARY_VALID:
                    cfg.primary_valid    = data[0];
                wls_pkg::REG_BACKUP_ADDR:
                    cfg.backup_addr      = data[wls_pkg::ADDR_W-1:0];
                wls_pkg::REG_BACKUP_VALID:
                    cfg.backup_valid     = data[0];
                default: ;
            endcase
        endfunction

        function void clear_link();
            bad_cnt  = '0;
            last_bad = '0;
            last_msg = '0;
            wait_rc  = 1'b0;
            is_conn  = 1'b0;
        endfunction

        function void note_item(wls_pkg::item_t it);
            logic                       warn;
            logic                       drop;
            wls_pkg::event_t            ev;
            logic [wls_pkg::TIME_W-1:0] lag;
            logic [wls_pkg::TIME_W:0]   window_end;
            wls_pkg::result_t           r;
            warn = 1'b0;
            drop = 1'b0;
            ev   = wls_pkg::EV_NONE;
            if (it.func)
            begin
                last_msg = it.now_ms;
                is_conn  = 1'b1;
                if ((cfg.primary_valid && it.device_addr == cfg.primary_addr) ||
                    (cfg.backup_valid && it.device_addr == cfg.backup_addr) ||
                    (learned_ok && it.device_addr == learned))
                begin
                    ev = wls_pkg::EV_ACCEPTED;
                end
                else if (!cfg.primary_valid && !learned_ok)
                begin
                    learned    = it.device_addr;
                    learned_ok = 1'b1;
                    ev         = wls_pkg::EV_LEARNED;
                end
                else
                begin
                    clear_link();
                    drop = 1'b1;
                    ev   = wls_pkg::EV_REJECTED;
                end
            end
            else if (is_conn)
            begin
                if (!it.link_up)
                begin
                    wait_rc = 1'b1;
                    is_conn = 1'b0;
                    ev      = wls_pkg::EV_LOST;
                end
                else
                begin
                    if (it.reported_time > last_msg)
                        last_msg = it.reported_time;
                    lag = it.now_ms - last_msg;
                    if (wait_rc)
                    begin
                        if (lag < {16'b0, cfg.active_timeout})
                            wait_rc = 1'b0;
                        last_msg = it.now_ms;
                    end
                    lag  = (it.now_ms > last_msg) ? it.now_ms - last_msg : '0;
                    warn = cfg.critical && (lag > {16'b0, cfg.active_timeout});
                    if (lag > {16'b0, cfg.inactive_timeout})
                    begin
                        clear_link();
                        wait_rc = 1'b1;
                        drop    = 1'b1;
                        ev      = wls_pkg::EV_INACTIVE;
                    end
                    else if (!it.status_known)
                    begin
                        window_end = {1'b0, last_bad} + {17'b0, cfg.bad_window};
                        if ({1'b0, it.now_ms} > window_end)
                        begin
                            if (bad_cnt < wls_pkg::BAD_SAT)
                                bad_cnt = bad_cnt + 1'b1;
                            last_bad = it.now_ms;
                        end
                        if (bad_cnt > wls_pkg::BAD_LIMIT)
                        begin
                            clear_link();
                            wait_rc = 1'b1;
                            drop    = 1'b1;
                            ev      = wls_pkg::EV_BAD_DATA;
                        end
                    end
                    else
                    begin
                        bad_cnt = '0;
                    end
                end
            end
            r.connected         = is_conn;
            r.waiting_reconnect = wait_rc;
            r.active_warn       = warn;
            r.drop_link         = drop;
            r.event_code        = ev;
            expected_status.push_back(r);
            ev_count[int'(ev)]++;
            items++;
        endfunction

        function void check_result(wls_pkg::result_t got);
            wls_pkg::result_t exp;
            if (expected_status.size() == 0)
            begin
                $error("result item with no expectation pending");
                errors++;
                return;
            end
            exp = expected_status.pop_front();
            if (got.connected !== exp.connected)
            begin
                $error("connected: expected %0d, actual %0d", exp.connected, got.connected);
                errors++;
            end
            if (got.waiting_reconnect !== exp.waiting_reconnect)
            begin
                $error("waiting_reconnect: expected %0d, actual %0d",
                       exp.waiting_reconnect, got.waiting_reconnect);
                errors++;
            end
            if (got.active_warn !== exp.active_warn)
            begin
                $error("active_warn: expected %0d, actual %0d", exp.active_warn, got.active_warn);
                errors++;
            end
            if (got.drop_link !== exp.drop_link)
            begin
                $error("drop_link: expected %0d, actual %0d", exp.drop_link, got.drop_link);
                errors++;
            end
            if (got.event_code !== exp.event_code)
            begin
                $error("event_code: expected %0d, actual %0d", exp.event_code, got.event_code);
                errors++;
            end
        endfunction

        function int pending();
            return expected_status.size();
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_wr_en;
    logic [wls_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [wls_pkg::CFG_DATA_W-1:0] cfg_data;
    bit                             src_idle;
    bit                             sink_idle;
    int                             settings;
    link_scoreboard                 sb = new();

    wls_item_if   item_ch ();
    wls_result_if result_ch ();

    wireless_link_supervisor_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL wireless_link_supervisor_top");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && item_ch.valid && item_ch.ready)
            sb.note_item('{func: item_ch.func, now_ms: item_ch.now_ms,
                           reported_time: item_ch.reported_time, link_up: item_ch.link_up,
                           status_known: item_ch.status_known,
                           device_addr: item_ch.device_addr});
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.check_result('{connected: result_ch.connected,
                              waiting_reconnect: result_ch.waiting_reconnect,
                              active_warn: result_ch.active_warn,
                              drop_link: result_ch.drop_link,
                              event_code: result_ch.event_code});
    end

    // result sink: random stall before each item while sink_idle is set
    initial
    begin
        int stall;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = sink_idle ? $urandom_range(0, 4) : 0;
            @(negedge clk);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
        end
    end

    function automatic wls_pkg::item_t mk(logic f, logic [wls_pkg::TIME_W-1:0] now,
                                          logic [wls_pkg::TIME_W-1:0] rep, logic up,
                                          logic known, logic [wls_pkg::ADDR_W-1:0] addr);
        wls_pkg::item_t it;
        it.func          = f;
        it.now_ms        = now;
        it.reported_time = rep;
        it.link_up       = up;
        it.status_known  = known;
        it.device_addr   = addr;
        return it;
    endfunction

    function automatic logic [wls_pkg::ADDR_W-1:0] rand_addr();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[wls_pkg::ADDR_W-1:0];
    endfunction

    function automatic logic [wls_pkg::TMO_W-1:0] pick_timeout();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(1, 400));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_item(wls_pkg::item_t it);
        int gap;
        gap = src_idle ? $urandom_range(0, 4) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.func          <= it.func;
        item_ch.now_ms        <= it.now_ms;
        item_ch.reported_time <= it.reported_time;
        item_ch.link_up       <= it.link_up;
        item_ch.status_known  <= it.status_known;
        item_ch.device_addr   <= it.device_addr;
        do @(posedge clk); while (!item_ch.ready);
    endtask

    // drop valid and wait until every expected result is back
    task automatic settle();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(wls_pkg::cfg_idx_t idx, logic [wls_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        logic [wls_pkg::ADDR_W-1:0] learn_a;
        logic [wls_pkg::ADDR_W-1:0] paddr;
        logic [wls_pkg::ADDR_W-1:0] baddr;
        logic [wls_pkg::ADDR_W-1:0] dev;
        logic [wls_pkg::TIME_W-1:0] clock_ms;
        logic [wls_pkg::TIME_W-1:0] rep;
        logic [wls_pkg::TMO_W-1:0]  win;
        int                         phase;
        int                         sent;
        int                         kind;
        int                         len;
        int                         pick;

        rst_n                 = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        item_ch.valid         = 1'b0;
        item_ch.func          = 1'b0;
        item_ch.now_ms        = '0;
        item_ch.reported_time = '0;
        item_ch.link_up       = 1'b0;
        item_ch.status_known  = 1'b0;
        item_ch.device_addr   = '0;
        src_idle              = 1'b1;
        sink_idle             = 1'b1;
        settings              = 1;
        learn_a               = 48'hFFFF_FFFF_FFFF;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed, reset configuration
        send_item(mk(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 48'hFFFF_FFFF_FFFF));
        send_item(mk(1, 100, 0, 1, 1, learn_a));
        send_item(mk(1, 150, 0, 1, 1, learn_a));
        send_item(mk(1, 160, 0, 1, 1, 48'h0));
        send_item(mk(0, 170, 0, 1, 1, 48'h0));
        send_item(mk(1, 1000, 0, 1, 1, learn_a));
        send_item(mk(0, 1010, 0, 0, 1, 48'h0));
        send_item(mk(1, 2000, 0, 1, 1, learn_a));
        send_item(mk(0, 2100, 0, 1, 1, 48'h0));
        send_item(mk(0, 2400, 2300, 1, 1, 48'h0));
        send_item(mk(0, 20000, 0, 1, 1, 48'h0));
        send_item(mk(1, 20010, 0, 1, 1, learn_a));
        send_item(mk(0, 30000, 0, 1, 1, 48'h0));
        send_item(mk(0, 30100, 30100, 1, 0, 48'h0));
        send_item(mk(0, 30120, 30120, 1, 0, 48'h0));
        send_item(mk(0, 30200, 30200, 1, 1, 48'h0));
        settle();

        // directed, extreme configuration with both address slots
        paddr = 48'h0123_4567_89AB;
        baddr = 48'hFEDC_BA98_7654;
        write_reg(wls_pkg::REG_ACTIVE_TIMEOUT, '0);
        write_reg(wls_pkg::REG_INACTIVE_TIMEOUT, 48'hFFFF);
        write_reg(wls_pkg::REG_BAD_WINDOW, 48'hFFFF);
        write_reg(wls_pkg::REG_CRITICAL, 48'h1);
        write_reg(wls_pkg::REG_PRIMARY_ADDR, paddr);
        write_reg(wls_pkg::REG_PRIMARY_VALID, 48'h1);
        write_reg(wls_pkg::REG_BACKUP_ADDR, baddr);
        write_reg(wls_pkg::REG_BACKUP_VALID, 48'h1);
        settings++;
        send_item(mk(1, 10, 0, 1, 1, paddr));
        send_item(mk(1, 20, 0, 1, 1, baddr));
        send_item(mk(1, 30, 0, 1, 1, learn_a));
        send_item(mk(1, 40, 0, 1, 1, 48'h5555_5555_5555));
        send_item(mk(1, 0, 0, 1, 1, paddr));
        send_item(mk(0, 5, 0, 1, 1, 48'h0));
        send_item(mk(0, 32'h0002_0000, 0, 1, 1, 48'h0));
        send_item(mk(1, 32'hFFFF_FF00, 0, 1, 1, baddr));
        send_item(mk(0, 32'hFFFF_FF10, 32'hFFFF_FF10, 1, 0, 48'h0));
        send_item(mk(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 48'h0));
        settle();

        clock_ms = 32'd1000;
        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:       win = '0;
                1:       win = 16'hFFFF;
                default: win = pick_timeout();
            endcase
            paddr = rand_addr();
            baddr = rand_addr();
            write_reg(wls_pkg::REG_ACTIVE_TIMEOUT, (phase == 0) ? 48'h0 :
                      (phase == 1) ? 48'hFFFF : 48'(pick_timeout()));
            write_reg(wls_pkg::REG_INACTIVE_TIMEOUT, (phase == 0) ? 48'hFFFF :
                      (phase == 1) ? 48'h0 : 48'(pick_timeout()));
            write_reg(wls_pkg::REG_BAD_WINDOW, 48'(win));
            write_reg(wls_pkg::REG_CRITICAL, 48'($urandom_range(0, 1)));
            write_reg(wls_pkg::REG_PRIMARY_ADDR, paddr);
            write_reg(wls_pkg::REG_PRIMARY_VALID, 48'($urandom_range(0, 1)));
            write_reg(wls_pkg::REG_BACKUP_ADDR, baddr);
            write_reg(wls_pkg::REG_BACKUP_VALID, 48'($urandom_range(0, 1)));
            settings++;
            src_idle  = (phase != 2);
            sink_idle = (phase != 3);
            sent = 0;
            while (sent < 100)
            begin
                kind = $urandom_range(0, 9);
                if (kind >= 8)
                begin
                    send_item(mk(1'($urandom_range(0, 1)), $urandom(), $urandom(),
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 rand_addr()));
                    sent++;
                end
                else
                begin
                    pick = $urandom_range(0, 3);
                    case (pick)
                        0:       dev = paddr;
                        1:       dev = baddr;
                        2:       dev = learn_a;
                        default: dev = rand_addr();
                    endcase
                    send_item(mk(1, clock_ms, $urandom(), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)), dev));
                    sent++;
                    len = (kind >= 6) ? $urandom_range(12, 16) : $urandom_range(3, 16);
                    repeat (len)
                    begin
                        if (kind >= 6)
                        begin
                            clock_ms = clock_ms + win + 1 + $urandom_range(0, 20);
                            send_item(mk(0, clock_ms, clock_ms, 1,
                                         ($urandom_range(0, 19) == 0), rand_addr()));
                        end
                        else
                        begin
                            if ($urandom_range(0, 9) == 0)
                                clock_ms = clock_ms + $urandom_range(0, 70000);
                            else
                                clock_ms = clock_ms + $urandom_range(0, 400);
                            case ($urandom_range(0, 5))
                                0, 1:    rep = clock_ms;
                                2:       rep = clock_ms - $urandom_range(0, 300);
                                3:       rep = clock_ms + $urandom_range(0, 300);
                                4:       rep = $urandom();
                                default: rep = '0;
                            endcase
                            send_item(mk(0, clock_ms, rep, ($urandom_range(0, 15) != 0),
                                         ($urandom_range(0, 3) != 0), rand_addr()));
                        end
                        sent++;
                    end
                end
            end
            settle();
        end

        repeat (10) @(posedge clk);
        $display("Ran %0d items under %0d register settings; results: %0d accepted, %0d learned,",
                 sb.items, settings, sb.ev_count[wls_pkg::EV_ACCEPTED],
                 sb.ev_count[wls_pkg::EV_LEARNED]);
        $display("  %0d rejected, %0d lost, %0d inactive timeouts, %0d bad-data drops",
                 sb.ev_count[wls_pkg::EV_REJECTED], sb.ev_count[wls_pkg::EV_LOST],
                 sb.ev_count[wls_pkg::EV_INACTIVE], sb.ev_count[wls_pkg::EV_BAD_DATA]);
        if (sb.errors == 0)
            $display("PASS wireless_link_supervisor_top");
        else
            $display("FAIL wireless_link_supervisor_top");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/wls_pkg.sv
rtl/wls_item_if.sv
rtl/wls_result_if.sv
rtl/wls_cfg.sv
rtl/wls_core.sv
rtl/wireless_link_supervisor_top.sv
rtl/wls_checker.sv
verif/testbench.sv
